FILE: hw/rtl/isrf_pkg.sv
// ----------------------------------------------------------------------------
// isrf_pkg
// Shared types, codes and helpers of the I2C slave register file.
// ----------------------------------------------------------------------------
`default_nettype none

package isrf_pkg;

  // register map size
  localparam int NumRegsDefault = 64;

  // depth of the command queue between front and back
  localparam int QueueDepth = 4;

  // configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 64;

  localparam logic [CfgIdxW-1:0] CFG_WRITABLE_MAP   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_SETTINGS_ADDR  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_STATUS_ADDR    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_LAST_DATA_ADDR = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_READY_BIT      = 3'd4;

  // function codes of an input word
  localparam logic [1:0] FUNC_BUS      = 2'd0;
  localparam logic [1:0] FUNC_LOCAL_WR = 2'd1;
  localparam logic [1:0] FUNC_CLR_FLAG = 2'd2;

  // reported bus phase codes
  localparam logic [2:0] PHASE_CODE_IDLE  = 3'd0;
  localparam logic [2:0] PHASE_CODE_START = 3'd1;
  localparam logic [2:0] PHASE_CODE_ADDR  = 3'd2;
  localparam logic [2:0] PHASE_CODE_WRITE = 3'd3;
  localparam logic [2:0] PHASE_CODE_READ  = 3'd4;

  // transaction state
  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_START = 5'b00010,
    PH_ADDR  = 5'b00100,
    PH_WRITE = 5'b01000,
    PH_READ  = 5'b10000
  } phase_e;

  // one command from the front to the back
  typedef struct packed {
    logic       tx_valid;  // byte goes to the master
    logic       tx_rd;     // byte comes from the register at rd_addr
    logic [7:0] rd_addr;
    logic       we;        // one write, address in range
    logic       wbit;      // wdata is a one-hot bit to set, not a byte
    logic [7:0] waddr;
    logic [7:0] wdata;
    logic [7:0] lr_addr;   // local readback address
    logic       lr_in;     // readback address in range
    logic       flag;      // update flag after the word
    logic [2:0] phase;     // phase code after the word
  } cmd_t;

  function automatic logic [2:0] phase_code(phase_e ph);
    logic [2:0] code;
    case (ph)
      PH_IDLE:  code = PHASE_CODE_IDLE;
      PH_START: code = PHASE_CODE_START;
      PH_ADDR:  code = PHASE_CODE_ADDR;
      PH_WRITE: code = PHASE_CODE_WRITE;
      PH_READ:  code = PHASE_CODE_READ;
      default:  code = PHASE_CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/isrf_front.sv
// ----------------------------------------------------------------------------
// isrf_front
// Configuration registers, bus transaction state and pointer; turns each
// accepted word into one register file command.
// ----------------------------------------------------------------------------
`default_nettype none

module isrf_front #(
  parameter int NUM_REGS = isrf_pkg::NumRegsDefault
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire [isrf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire [isrf_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire                          acc_i,
  input  wire [1:0]                    func_i,
  input  wire                          start_seen_i,
  input  wire                          stop_seen_i,
  input  wire                          data_seen_i,
  input  wire                          master_reads_i,
  input  wire [7:0]                    rx_byte_i,
  input  wire [7:0]                    local_addr_i,
  input  wire [7:0]                    local_data_i,
  output isrf_pkg::cmd_t               cmd_o
);
  import isrf_pkg::*;

  logic [63:0] writable_map_q;
  logic [5:0]  settings_addr_q;
  logic [5:0]  status_addr_q;
  logic [5:0]  last_data_addr_q;
  logic [2:0]  ready_bit_q;

  phase_e     phase_q, phase_d;
  logic [7:0] pointer_q, pointer_d;
  logic       flag_q, flag_d;

  logic ptr_in, status_in, can_write;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      writable_map_q   <= '0;
      settings_addr_q  <= 6'd0;
      status_addr_q    <= 6'd1;
      last_data_addr_q <= 6'd2;
      ready_bit_q      <= 3'd0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_WRITABLE_MAP:   writable_map_q   <= cfg_data_i;
        CFG_SETTINGS_ADDR:  settings_addr_q  <= cfg_data_i[5:0];
        CFG_STATUS_ADDR:    status_addr_q    <= cfg_data_i[5:0];
        CFG_LAST_DATA_ADDR: last_data_addr_q <= cfg_data_i[5:0];
        CFG_READY_BIT:      ready_bit_q      <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // range and permission checks on the current pointer and the status address
  assign ptr_in    = pointer_q < 8'(NUM_REGS);
  assign status_in = {2'b00, status_addr_q} < 8'(NUM_REGS);
  assign can_write = ptr_in && writable_map_q[pointer_q[5:0]];

  // classify the word and work out the next state
  always_comb begin
    phase_d   = phase_q;
    pointer_d = pointer_q;
    flag_d    = flag_q;
    cmd_o     = '0;
    case (func_i)
      FUNC_BUS: begin
        if (start_seen_i) begin
          phase_d = (phase_q == PH_IDLE) ? PH_START : PH_READ;
        end
        if (stop_seen_i) begin
          phase_d = PH_IDLE;
        end
        if (data_seen_i) begin
          if (master_reads_i) begin
            cmd_o.tx_valid = 1'b1;
            if (phase_d inside {PH_ADDR, PH_WRITE}) begin
              cmd_o.tx_rd   = ptr_in;
              cmd_o.rd_addr = pointer_q;
              pointer_d     = pointer_q + 8'd1;
              phase_d       = (phase_d == PH_WRITE) ? PH_WRITE : PH_READ;
            end else if (phase_d == PH_READ) begin
              cmd_o.tx_rd   = ptr_in;
              cmd_o.rd_addr = pointer_q;
              // read of the last data register sets the ready bit
              if (pointer_q == {2'b00, last_data_addr_q} && status_in) begin
                cmd_o.we    = 1'b1;
                cmd_o.wbit  = 1'b1;
                cmd_o.waddr = {2'b00, status_addr_q};
                cmd_o.wdata = 8'd1 << ready_bit_q;
              end
              pointer_d = pointer_q + 8'd1;
            end
          end else begin
            if (phase_d == PH_START) begin
              pointer_d = rx_byte_i;
              phase_d   = PH_ADDR;
            end else if (phase_d inside {PH_ADDR, PH_WRITE}) begin
              if (can_write) begin
                if (pointer_q == {2'b00, settings_addr_q}) begin
                  flag_d = 1'b1;
                end
                cmd_o.we    = 1'b1;
                cmd_o.waddr = pointer_q;
                cmd_o.wdata = rx_byte_i;
                pointer_d   = pointer_q + 8'd1;
                phase_d     = PH_WRITE;
              end
            end
          end
        end
      end
      FUNC_LOCAL_WR: begin
        if (local_addr_i < 8'(NUM_REGS)) begin
          cmd_o.we    = 1'b1;
          cmd_o.waddr = local_addr_i;
          cmd_o.wdata = local_data_i;
        end
      end
      FUNC_CLR_FLAG: flag_d = 1'b0;
      default: ;
    endcase
    cmd_o.lr_addr = local_addr_i;
    cmd_o.lr_in   = local_addr_i < 8'(NUM_REGS);
    cmd_o.flag    = flag_d;
    cmd_o.phase   = phase_code(phase_d);
  end

  // transaction state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      pointer_q <= 8'd0;
      flag_q    <= 1'b0;
    end else if (acc_i) begin
      phase_q   <= phase_d;
      pointer_q <= pointer_d;
      flag_q    <= flag_d;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/isrf_queue.sv
// ----------------------------------------------------------------------------
// isrf_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module isrf_queue (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             push_i,
  input  isrf_pkg::cmd_t  cmd_i,
  output logic            full_o,
  input  wire             pop_i,
  output logic            valid_o,
  output isrf_pkg::cmd_t  cmd_o
);
  import isrf_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);

  cmd_t            slot_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   count_q, count_d;

  logic do_push, do_pop;

  assign full_o  = count_q == (PtrW+1)'(QueueDepth);
  assign valid_o = count_q != '0;
  assign cmd_o   = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
    end
  end

  // slots
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/isrf_back.sv
// ----------------------------------------------------------------------------
// isrf_back
// Register file and result register; a command a cycle unless a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module isrf_back #(
  parameter int NUM_REGS = isrf_pkg::NumRegsDefault
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             cmd_valid_i,
  input  isrf_pkg::cmd_t  cmd_i,
  output logic            cmd_ready_o,
  output logic            res_empty_o,
  input  wire             res_pop_i,
  output logic            tx_valid_o,
  output logic [7:0]      tx_byte_o,
  output logic            update_flag_o,
  output logic [2:0]      bus_phase_o,
  output logic [7:0]      local_read_data_o
);
  import isrf_pkg::*;

  localparam int AW = $clog2(NUM_REGS);

  logic [7:0]          mem_q [NUM_REGS];
  logic [NUM_REGS-1:0] vld_q;

  logic          issue;
  logic [AW-1:0] rd_idx, wr_idx, lr_idx;
  logic [7:0]    wmask, wdata;

  logic       res_valid_q, res_valid_d;
  logic [7:0] tx_raw_q, lr_raw_q;
  logic       tx_valid_q, tx_use_q, lr_use_q, hit_q, flag_q;
  logic [7:0] fmask_q, fdata_q;
  logic [2:0] phase_q;
  logic [7:0] lr_base;

  assign cmd_ready_o = !res_valid_q || res_pop_i;
  assign issue       = cmd_valid_i && cmd_ready_o;

  assign rd_idx = cmd_i.rd_addr[AW-1:0];
  assign wr_idx = cmd_i.waddr[AW-1:0];
  assign lr_idx = cmd_i.lr_addr[AW-1:0];

  // setting a bit in a never written entry writes the whole byte
  always_comb begin
    if (cmd_i.wbit && vld_q[wr_idx]) begin
      wmask = cmd_i.wdata;
      wdata = 8'hFF;
    end else begin
      wmask = 8'hFF;
      wdata = cmd_i.wdata;
    end
  end

  // register file, bit-enabled write, two registered reads of old data
  always_ff @(posedge clk_i) begin
    if (issue) begin
      if (cmd_i.we) begin
        for (int b = 0; b < 8; b++) begin
          if (wmask[b]) begin
            mem_q[wr_idx][b] <= wdata[b];
          end
        end
      end
      tx_raw_q <= mem_q[rd_idx];
      lr_raw_q <= mem_q[lr_idx];
    end
  end

  // written entries; others read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (issue && cmd_i.we) begin
      vld_q[wr_idx] <= 1'b1;
    end
  end

  // result register
  always_comb begin
    res_valid_d = res_valid_q;
    if (issue) begin
      res_valid_d = 1'b1;
    end else if (res_pop_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      tx_valid_q <= cmd_i.tx_valid;
      tx_use_q   <= cmd_i.tx_rd && vld_q[rd_idx];
      lr_use_q   <= cmd_i.lr_in && vld_q[lr_idx];
      hit_q      <= cmd_i.we && cmd_i.lr_in && (lr_idx == wr_idx);
      fmask_q    <= wmask;
      fdata_q    <= wdata;
      flag_q     <= cmd_i.flag;
      phase_q    <= cmd_i.phase;
    end
  end

  // readback sees the write of the same word
  assign lr_base = lr_use_q ? lr_raw_q : 8'h00;

  assign res_empty_o       = !res_valid_q;
  assign tx_valid_o        = tx_valid_q;
  assign tx_byte_o         = tx_use_q ? tx_raw_q : 8'h00;
  assign update_flag_o     = flag_q;
  assign bus_phase_o       = phase_q;
  assign local_read_data_o = hit_q ? ((lr_base & ~fmask_q) | (fdata_q & fmask_q)) : lr_base;

endmodule

`default_nettype wire

FILE: hw/rtl/i2c_slave_register_file_unit.sv
// ----------------------------------------------------------------------------
// i2c_slave_register_file_unit
// Register map behind an I2C slave with auto-incrementing pointer.
// ----------------------------------------------------------------------------
// One word is taken every clock cycle unless the queue is full. The front keeps
// the transaction phase, the pointer and the update flag and turns each word
// into a register file command in the cycle it is taken; the back executes one
// command per cycle unless a result waits, on a memory with one write port and
// two read ports; a command passes a queue slot, then the result register. A
// four-entry command queue lets the input side keep going while results wait
// to be popped. Register file contents read as zero until written, tracked by
// one valid bit per entry; no clearing pass is needed after reset.
`default_nettype none

module i2c_slave_register_file_unit #(
  parameter int NUM_REGS = isrf_pkg::NumRegsDefault
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire [isrf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire [isrf_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire                          push,
  output logic                         full,
  input  wire [1:0]                    func_i,
  input  wire                          start_seen_i,
  input  wire                          stop_seen_i,
  input  wire                          data_seen_i,
  input  wire                          master_reads_i,
  input  wire [7:0]                    rx_byte_i,
  input  wire [7:0]                    local_addr_i,
  input  wire [7:0]                    local_data_i,
  output logic                         empty,
  input  wire                          pop,
  output logic                         tx_valid_o,
  output logic [7:0]                   tx_byte_o,
  output logic                         update_flag_o,
  output logic [2:0]                   bus_phase_o,
  output logic [7:0]                   local_read_data_o
);
  import isrf_pkg::*;

  cmd_t front_cmd, queue_cmd;
  logic acc, q_full, q_valid, q_pop;

  assign full = q_full;
  assign acc  = push && !q_full;

  // front: state and classification
  isrf_front #(
    .NUM_REGS (NUM_REGS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .acc_i          (acc),
    .func_i         (func_i),
    .start_seen_i   (start_seen_i),
    .stop_seen_i    (stop_seen_i),
    .data_seen_i    (data_seen_i),
    .master_reads_i (master_reads_i),
    .rx_byte_i      (rx_byte_i),
    .local_addr_i   (local_addr_i),
    .local_data_i   (local_data_i),
    .cmd_o          (front_cmd)
  );

  // command queue
  isrf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (acc),
    .cmd_i   (front_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (queue_cmd)
  );

  // back: register file and results
  isrf_back #(
    .NUM_REGS (NUM_REGS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_valid_i       (q_valid),
    .cmd_i             (queue_cmd),
    .cmd_ready_o       (q_pop),
    .res_empty_o       (empty),
    .res_pop_i         (pop),
    .tx_valid_o        (tx_valid_o),
    .tx_byte_o         (tx_byte_o),
    .update_flag_o     (update_flag_o),
    .bus_phase_o       (bus_phase_o),
    .local_read_data_o (local_read_data_o)
  );

`ifndef SYNTH
  // a taken word is in the queue on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) acc |=> q_valid)
    else $error("accepted word missing from command queue");

  // a command taken by the back shows up as a result
  assert property (@(posedge clk_i) disable iff (!rst_ni) (q_pop && q_valid) |=> !empty)
    else $error("executed command produced no result");

  // no byte to the master without a data request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (tx_valid_o || tx_byte_o == 8'h00))
    else $error("tx byte set without tx valid");
`endif

endmodule

`default_nettype wire
